@@ hw/rtl/drkf_pkg.sv @@
// ----------------------------------------------------------------------------
// drkf_pkg
// shared types, constants and the sip round function for the fingerprint core
// ----------------------------------------------------------------------------
package drkf_pkg;

	localparam int unsigned NumRounds   = 18;  // 7 words x 2 rounds + 4 final
	localparam int unsigned AbsorbCells = 14;
	localparam int unsigned MsgWords    = 5;   // words taken from the record
	localparam int unsigned InWidth     = 272;
	localparam int unsigned OutWidth    = 64;
	localparam int unsigned BlockBytes  = 48;
	localparam int unsigned HalfRotate  = 32;

	localparam logic [63:0] InitV0 = 64'h736f6d6570736575;
	localparam logic [63:0] InitV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] InitV2 = 64'h6c7967656e657261;
	localparam logic [63:0] InitV3 = 64'h7465646279746573;
	localparam logic [63:0] LenWord = 64'(BlockBytes) << 56;

	typedef enum logic [1:0] {
		REG_KEY_A_LOW  = 2'd0,
		REG_KEY_A_HIGH = 2'd1,
		REG_KEY_B_LOW  = 2'd2,
		REG_KEY_B_HIGH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_t;

	typedef logic [MsgWords*64-1:0] msg_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

	function automatic sip_t sip_round(input sip_t s);
		sip_t t;
		t = s;
		t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 ^= t.v0; t.v0 = rotl(t.v0, 32);
		t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 ^= t.v2;
		t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 ^= t.v0;
		t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 ^= t.v2; t.v2 = rotl(t.v2, 32);
		return t;
	endfunction

endpackage

@@ hw/rtl/drkf_cell.sv @@
// ----------------------------------------------------------------------------
// drkf_cell
// one sip round on both key lanes, with the message xor that belongs to it
// ----------------------------------------------------------------------------
module drkf_cell import drkf_pkg::*; #(
	parameter int unsigned Idx = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sip_t in_a,
	input  sip_t in_b,
	input  msg_t in_msg,
	output logic out_valid,
	input  logic out_ready,
	output sip_t out_a,
	output sip_t out_b,
	output msg_t out_msg
);

	localparam int unsigned Word = Idx / 2;
	localparam bit PreXor  = (Idx % 2 == 0) && (Idx < AbsorbCells);
	localparam bit PostXor = (Idx % 2 == 1) && (Idx < AbsorbCells);
	localparam bit Finish  = (Idx == AbsorbCells - 1);

	logic        valid_q;
	sip_t        a_q, b_q;
	msg_t        msg_q;
	logic [63:0] m;
	sip_t        a_d, b_d;

	always_comb begin
		if (Word < MsgWords) begin
			m = in_msg[(Word % MsgWords)*64 +: 64];
		end else if (Word == MsgWords) begin
			m = '0;
		end else begin
			m = LenWord;
		end
		a_d = in_a;
		b_d = in_b;
		if (PreXor) begin
			a_d.v3 ^= m;
			b_d.v3 ^= m;
		end
		a_d = sip_round(a_d);
		b_d = sip_round(b_d);
		if (PostXor) begin
			a_d.v0 ^= m;
			b_d.v0 ^= m;
		end
		if (Finish) begin
			a_d.v2 ^= 64'hff;
			b_d.v2 ^= 64'hff;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_q   <= a_d;
			b_q   <= b_d;
			msg_q <= in_msg;
		end
	end

	assign out_valid = valid_q;
	assign out_a     = a_q;
	assign out_b     = b_q;
	assign out_msg   = msg_q;

endmodule

@@ hw/rtl/device_record_keyed_fingerprint.sv @@
// ----------------------------------------------------------------------------
// device_record_keyed_fingerprint
// keyed sip-2-4 fingerprint of a device record under two keys
// ----------------------------------------------------------------------------
// Each input word is one device record; it is packed into a 48-byte block and
// hashed with SipHash-2-4 under key A and key B at once. The fingerprint is
// hash A xor (hash B rotated left by 32). The core is a chain of 18 round
// cells, each running one sip round for both keys and registering the result,
// so a record is accepted every cycle when the output side does not stall.
// Each cell holds its word while stalled and frees as soon as its successor
// takes it, so bubbles close up. Keys are to be written by the user through
// the plain write port while the core is idle; the block does not enforce this.
module device_record_keyed_fingerprint import drkf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	// record input
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// vendor_code 16, device_code 16, subsystem_code 32, class_triple 24,
	// window_base 64, window_size 64, bus_number 8, slot_number 5,
	// function_number 3, irq_line 8, class_tag 32
	input  logic [InWidth-1:0]  s_axis_tdata,
	// fingerprint output
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// fingerprint 64
	output logic [OutWidth-1:0] m_axis_tdata
);

	logic [63:0] key_a_low_q, key_a_high_q, key_b_low_q, key_b_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_low_q  <= '0;
			key_a_high_q <= '0;
			key_b_low_q  <= '0;
			key_b_high_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KEY_A_LOW:  key_a_low_q  <= cfg_data;
				REG_KEY_A_HIGH: key_a_high_q <= cfg_data;
				REG_KEY_B_LOW:  key_b_low_q  <= cfg_data;
				REG_KEY_B_HIGH: key_b_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// block words 0..4, the zero word and the length word are made in the cells
	msg_t msg_in;
	assign msg_in = {
		s_axis_tdata[271:240], s_axis_tdata[239:232], 5'd0,
		s_axis_tdata[231:229], 3'd0, s_axis_tdata[228:224], s_axis_tdata[223:216],
		s_axis_tdata[215:152],
		s_axis_tdata[151:88],
		8'd0, s_axis_tdata[87:64], s_axis_tdata[63:32],
		16'd0, s_axis_tdata[31:16], 16'd0, s_axis_tdata[15:0]
	};

	sip_t init_a, init_b;
	assign init_a = '{v0: key_a_low_q ^ InitV0, v1: key_a_high_q ^ InitV1,
		v2: key_a_low_q ^ InitV2, v3: key_a_high_q ^ InitV3};
	assign init_b = '{v0: key_b_low_q ^ InitV0, v1: key_b_high_q ^ InitV1,
		v2: key_b_low_q ^ InitV2, v3: key_b_high_q ^ InitV3};

	// chain links: index k feeds cell k
	logic valid_c [NumRounds+1];
	logic ready_c [NumRounds+1];
	sip_t a_c     [NumRounds+1];
	sip_t b_c     [NumRounds+1];
	msg_t msg_c   [NumRounds+1];

	assign valid_c[0]    = s_axis_tvalid;
	assign s_axis_tready = ready_c[0];
	assign a_c[0]        = init_a;
	assign b_c[0]        = init_b;
	assign msg_c[0]      = msg_in;

	for (genvar k = 0; k < NumRounds; k++) begin : g_cell
		drkf_cell #(.Idx(k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[k]),
			.in_ready  (ready_c[k]),
			.in_a      (a_c[k]),
			.in_b      (b_c[k]),
			.in_msg    (msg_c[k]),
			.out_valid (valid_c[k+1]),
			.out_ready (ready_c[k+1]),
			.out_a     (a_c[k+1]),
			.out_b     (b_c[k+1]),
			.out_msg   (msg_c[k+1])
		);
	end

	// last cell is the output register; folding is plain xor
	logic [63:0] hash_a, hash_b;
	assign hash_a = a_c[NumRounds].v0 ^ a_c[NumRounds].v1 ^ a_c[NumRounds].v2
		^ a_c[NumRounds].v3;
	assign hash_b = b_c[NumRounds].v0 ^ b_c[NumRounds].v1 ^ b_c[NumRounds].v2
		^ b_c[NumRounds].v3;

	assign ready_c[NumRounds] = m_axis_tready;
	assign m_axis_tvalid      = valid_c[NumRounds];
	assign m_axis_tdata       = hash_a ^ rotl(hash_b, HalfRotate);

endmodule

@@ hw/rtl/drkf_checker.sv @@
// ----------------------------------------------------------------------------
// drkf_checker
// port-level checks on the fingerprint core
// ----------------------------------------------------------------------------
module drkf_checker import drkf_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutWidth-1:0] m_axis_tdata
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a free output frees the whole chain
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked with output ready");

	// input only blocks when a result is waiting
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input blocked without a waiting result");

	// no result is offered right after reset
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_axis_tvalid)
		else $error("result right after reset");

endmodule

bind device_record_keyed_fingerprint drkf_checker u_drkf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
